>>> design/cordic_rotate_vector_macros.svh
// Assertion macros for the CORDIC rotation and vectoring unit.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef CORDIC_ROTATE_VECTOR_MACROS_SVH
`define CORDIC_ROTATE_VECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define CRV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("CORDIC unit check failed");
`define CRV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("CORDIC unit check failed");
`else
`define CRV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CRV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/crv_pkg.sv
// Shared types, constants and ROMs for the CORDIC rotation and vectoring unit.
// No dependencies; used by every module of the block.
package crv_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int VEC_GUARD  = 8;
    localparam int XY_W       = 34;
    localparam int ACC_W      = 35;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = XY_W + GAIN_W + 1;
    localparam int PHASE_LIM  = 25736;
    localparam int TRIG_LIM   = 16384;

    localparam logic ACT_VECTOR = 1'b0;
    localparam logic ACT_ROTATE = 1'b1;

    localparam logic signed [ACC_W-1:0] HALF_PI_A = ACC_W'(1686629713);
    localparam logic signed [XY_W-1:0]  UNIT_A    = XY_W'(1073741824);

    localparam logic [29:0] ATAN_ROM [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    localparam logic [GAIN_W-1:0] INV_GAIN_ROM [16] = '{
        16'd46341, 16'd41449, 16'd40211, 16'd39901,
        16'd39823, 16'd39803, 16'd39799, 16'd39797,
        16'd39797, 16'd39797, 16'd39797, 16'd39797,
        16'd39797, 16'd39797, 16'd39797, 16'd39797
    };

    typedef struct packed {
        logic                         action;
        logic signed [DATA_WIDTH-1:0] in_x;
        logic signed [DATA_WIDTH-1:0] in_y;
        logic signed [15:0]           target_angle;
    } t_in_word;

    typedef struct packed {
        logic        [DATA_WIDTH-1:0] magnitude;
        logic signed [15:0]           phase;
        logic signed [15:0]           cosine;
        logic signed [15:0]           sine;
    } t_out_word;

    typedef struct packed {
        logic                    action;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] t;
    } t_stage;

endpackage

>>> design/cordic_rotate_vector.sv
// Top level of the pipelined circular CORDIC unit (vectoring and rotation).
// Depends on crv_pkg, crv_stage, crv_post and cordic_rotate_vector_macros.svh.
//
// Usage:
//   Input words arrive on i_word and are taken at a clock edge where start is
//   high and busy is low. busy is high only while reset is asserted, so one
//   word can be taken in every cycle.
//   Each word gives exactly one result word on o_word, marked by o_strobe for
//   one cycle. The path holds one pre-rotation register, one register per
//   micro-rotation stage, a gain multiply register and an output register.
//   Throughput is one word per cycle, set by the fully unrolled stage
//   chain.
//   The last_stage register is written through i_cfg_we and i_cfg_wdata and
//   should only change while no words are in flight. Stages past last_stage
//   pass their data through unchanged.
//   Synchronous reset empties the pipeline and sets last_stage to 15.
//   The receiver cannot stall; results appear whether or not it is ready.
`include "cordic_rotate_vector_macros.svh"

module cordic_rotate_vector import crv_pkg::*; #(
    parameter int MAX_STAGES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_word,
    input  logic      i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    localparam int         LATENCY   = MAX_STAGES + 3;
    localparam logic [4:0] STAGE_CAP = 5'(MAX_STAGES - 1);

    logic                   accept;
    logic [3:0]             r_last_stage;
    logic [3:0]             gain_idx;
    t_stage                 n_pre;
    t_stage                 r_pre;
    logic                   r_pre_valid;
    logic signed [XY_W-1:0] ix;
    logic signed [XY_W-1:0] iy;
    logic signed [ACC_W-1:0] t_ang;
    logic                   out_mode_ok;
    logic                   out_range_ok;

    logic   stage_valid [MAX_STAGES+1];
    t_stage stage_data  [MAX_STAGES+1];

    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stage <= 4'd15;
        end else if (i_cfg_we) begin
            r_last_stage <= i_cfg_wdata;
        end
    end

    always_comb begin
        if ({1'b0, r_last_stage} > STAGE_CAP) begin
            gain_idx = STAGE_CAP[3:0];
        end else begin
            gain_idx = r_last_stage;
        end
    end

    always_comb begin
        ix    = XY_W'(i_word.in_x);
        iy    = XY_W'(i_word.in_y);
        t_ang = ACC_W'(i_word.target_angle) <<< 17;
        n_pre        = '0;
        n_pre.action = i_word.action;
        n_pre.t      = t_ang;
        if (i_word.action == ACT_ROTATE) begin
            if (t_ang > HALF_PI_A) begin
                n_pre.y   = UNIT_A;
                n_pre.acc = HALF_PI_A;
            end else if (t_ang < -HALF_PI_A) begin
                n_pre.y   = -UNIT_A;
                n_pre.acc = -HALF_PI_A;
            end else begin
                n_pre.x   = UNIT_A;
            end
        end else begin
            if (ix < 0) begin
                if (iy > 0) begin
                    n_pre.x   = iy <<< VEC_GUARD;
                    n_pre.y   = (-ix) <<< VEC_GUARD;
                    n_pre.acc = -HALF_PI_A;
                end else begin
                    n_pre.x   = (-iy) <<< VEC_GUARD;
                    n_pre.y   = ix <<< VEC_GUARD;
                    n_pre.acc = HALF_PI_A;
                end
            end else begin
                n_pre.x = ix <<< VEC_GUARD;
                n_pre.y = iy <<< VEC_GUARD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else begin
            r_pre_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre <= n_pre;
    end

    assign stage_valid[0] = r_pre_valid;
    assign stage_data[0]  = r_pre;

    for (genvar gi = 0; gi < MAX_STAGES; gi++) begin : g_stage
        crv_stage #(
            .STAGE_IDX(gi)
        ) u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_last_stage(r_last_stage),
            .i_valid     (stage_valid[gi]),
            .i_data      (stage_data[gi]),
            .o_valid     (stage_valid[gi+1]),
            .o_data      (stage_data[gi+1])
        );
    end

    crv_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gain_idx(gain_idx),
        .i_valid   (stage_valid[MAX_STAGES]),
        .i_data    (stage_data[MAX_STAGES]),
        .o_valid   (o_strobe),
        .o_word    (o_word)
    );

    assign out_mode_ok  = (o_word.cosine == 16'sd0 && o_word.sine == 16'sd0)
                       || (o_word.magnitude == '0 && o_word.phase == 16'sd0);
    assign out_range_ok = o_word.phase >= -PHASE_LIM && o_word.phase <= PHASE_LIM
                       && o_word.cosine >= -TRIG_LIM && o_word.cosine <= TRIG_LIM
                       && o_word.sine >= -TRIG_LIM && o_word.sine <= TRIG_LIM;

    // Every accepted word gives a result marked by o_strobe.
    `CRV_ASSERT_NXT(a_latency, i_clk, i_rst_n, accept, ##(LATENCY - 1) o_strobe)
    // A result carries either the vectoring pair or the rotation pair, never both.
    `CRV_ASSERT_IMP(a_mode_fields, i_clk, i_rst_n, o_strobe, out_mode_ok)
    // Saturation keeps phase and trig outputs inside their ranges.
    `CRV_ASSERT_IMP(a_out_range, i_clk, i_rst_n, o_strobe, out_range_ok)

endmodule

>>> design/crv_stage.sv
// One registered CORDIC micro-rotation stage with a fixed shift of STAGE_IDX.
// Depends on crv_pkg for the stage word type and the arctangent ROM.
module crv_stage import crv_pkg::*; #(
    parameter int STAGE_IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_last_stage,
    input  logic       i_valid,
    input  t_stage     i_data,
    output logic       o_valid,
    output t_stage     o_data
);

    localparam logic [5:0]              IDX    = 6'(STAGE_IDX);
    localparam logic signed [ACC_W-1:0] ATAN_L = ACC_W'(ATAN_ROM[STAGE_IDX]);

    logic                   active;
    logic                   neg;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    t_stage                 n_data;
    t_stage                 r_data;
    logic                   r_valid;

    always_comb begin
        active = IDX <= {2'b00, i_last_stage};
        x_sh   = i_data.x >>> STAGE_IDX;
        y_sh   = i_data.y >>> STAGE_IDX;
        if (i_data.action == ACT_ROTATE) begin
            neg = i_data.t < i_data.acc;
        end else begin
            neg = !i_data.y[XY_W-1];
        end
        n_data = i_data;
        if (active) begin
            if (neg) begin
                n_data.x   = i_data.x + y_sh;
                n_data.y   = i_data.y - x_sh;
                n_data.acc = i_data.acc - ATAN_L;
            end else begin
                n_data.x   = i_data.x - y_sh;
                n_data.y   = i_data.y + x_sh;
                n_data.acc = i_data.acc + ATAN_L;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/crv_post.sv
// Gain correction and output scaling: a multiply stage, then rounding and saturation.
// Depends on crv_pkg for the stage word, the output word and the inverse-gain ROM.
module crv_post import crv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_gain_idx,
    input  logic       i_valid,
    input  t_stage     i_data,
    output logic       o_valid,
    output t_out_word  o_word
);

    localparam logic signed [PROD_W-1:0] MAG_RND  = PROD_W'(1) <<< (15 + VEC_GUARD);
    localparam logic signed [PROD_W-1:0] TRIG_RND = PROD_W'(1) <<< 31;
    localparam logic signed [PROD_W-1:0] MAG_HI   = PROD_W'((1 << DATA_WIDTH) - 1);
    localparam logic signed [PROD_W-1:0] TRIG_HI  = PROD_W'(TRIG_LIM);
    localparam logic signed [PROD_W-1:0] TRIG_LO  = -TRIG_HI;
    localparam logic signed [ACC_W:0]    PH_RND   = (ACC_W + 1)'(65536);
    localparam logic signed [ACC_W:0]    PH_HI    = (ACC_W + 1)'(PHASE_LIM);
    localparam logic signed [ACC_W:0]    PH_LO    = -PH_HI;

    logic signed [GAIN_W:0]   gain;
    logic signed [PROD_W-1:0] n_prod_x;
    logic signed [PROD_W-1:0] n_prod_y;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_action;
    logic                     r_mul_valid;

    logic signed [PROD_W-1:0] mag_full;
    logic signed [PROD_W-1:0] cos_full;
    logic signed [PROD_W-1:0] sin_full;
    logic signed [ACC_W:0]    ph_full;
    logic        [DATA_WIDTH-1:0] mag_sat;
    logic signed [15:0]       cos_sat;
    logic signed [15:0]       sin_sat;
    logic signed [15:0]       ph_sat;
    t_out_word                n_word;
    t_out_word                r_word;
    logic                     r_out_valid;

    always_comb begin
        gain     = $signed({1'b0, INV_GAIN_ROM[i_gain_idx]});
        n_prod_x = PROD_W'(i_data.x) * PROD_W'(gain);
        n_prod_y = PROD_W'(i_data.y) * PROD_W'(gain);
    end

    always_ff @(posedge i_clk) begin
        r_prod_x <= n_prod_x;
        r_prod_y <= n_prod_y;
        r_acc    <= i_data.acc;
        r_action <= i_data.action;
    end

    always_comb begin
        mag_full = (r_prod_x + MAG_RND) >>> (16 + VEC_GUARD);
        cos_full = (r_prod_x + TRIG_RND) >>> 32;
        sin_full = (r_prod_y + TRIG_RND) >>> 32;
        ph_full  = (PH_RND - (ACC_W + 1)'(r_acc)) >>> 17;

        if (mag_full < 0) begin
            mag_sat = '0;
        end else if (mag_full > MAG_HI) begin
            mag_sat = '1;
        end else begin
            mag_sat = mag_full[DATA_WIDTH-1:0];
        end

        if (cos_full > TRIG_HI) begin
            cos_sat = TRIG_HI[15:0];
        end else if (cos_full < TRIG_LO) begin
            cos_sat = TRIG_LO[15:0];
        end else begin
            cos_sat = cos_full[15:0];
        end

        if (sin_full > TRIG_HI) begin
            sin_sat = TRIG_HI[15:0];
        end else if (sin_full < TRIG_LO) begin
            sin_sat = TRIG_LO[15:0];
        end else begin
            sin_sat = sin_full[15:0];
        end

        if (ph_full > PH_HI) begin
            ph_sat = PH_HI[15:0];
        end else if (ph_full < PH_LO) begin
            ph_sat = PH_LO[15:0];
        end else begin
            ph_sat = ph_full[15:0];
        end

        n_word = '0;
        if (r_action == ACT_ROTATE) begin
            n_word.cosine = cos_sat;
            n_word.sine   = sin_sat;
        end else begin
            n_word.magnitude = mag_sat;
            n_word.phase     = ph_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_valid <= i_valid;
            r_out_valid <= r_mul_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_word;

endmodule
